@@ rtl/core/bbta_pkg.sv @@
// Shared types and constants of the buddy bitmap tree allocator.
// Holds the command and status structs that join the controller and the datapath.
// No dependencies.
package bbta_pkg;

  localparam int unsigned CFG_W = 4;
  localparam logic [CFG_W-1:0] LEVELS_RESET = 4'd8;

  // Result status codes.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // What the current bitmap row pass is doing.
  typedef enum logic [2:0] {
    PH_SCAN,  // search a level for a free node
    PH_ANC,   // mark one ancestor busy
    PH_SUB,   // write one level of the subtree
    PH_TEST,  // test the buddy of the walk node
    PH_CLRP   // clear the parent during the free walk
  } phase_e;

  typedef struct packed {
    logic       load;
    logic       start;
    logic       act;
    logic       next_row;
    logic       anc_step;
    logic       sub_init;
    logic       sub_step;
    logic       walk_init;
    logic       walk_step;
    logic       init_wr;
    logic       finish;
    phase_e     phase;
    logic [1:0] fin_status;
  } cmd_t;

  typedef struct packed {
    logic range_err;
    logic is_free;
    logic hit;
    logic last_row;
    logic anc_zero;
    logic sub_more;
    logic lv_zero;
    logic out_busy;
    logic init_last;
  } sts_t;

endpackage

@@ rtl/core/bbta_ctrl.sv @@
// Controller state machine of the buddy bitmap tree allocator.
// Sequences the row passes of each request; depends on bbta_pkg.
module bbta_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bbta_pkg::sts_t sts_i,
  output bbta_pkg::cmd_t cmd_o
);
  import bbta_pkg::*;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_ACT   = 4'd4;
  localparam logic [3:0] S_ANC   = 4'd5;
  localparam logic [3:0] S_SUB   = 4'd6;
  localparam logic [3:0] S_WALK  = 4'd7;
  localparam logic [3:0] S_PAR   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0] state_q, state_d;
  phase_e     ph_q, ph_d;
  logic [1:0] st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      ph_q    <= PH_SCAN;
      st_q    <= ST_DONE;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      st_q    <= st_d;
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.phase      = ph_q;
    cmd_o.fin_status = st_q;
    state_d          = state_q;
    ph_d             = ph_q;
    st_d             = st_q;
    in_ready_o       = 1'b0;
    unique case (state_q)
      S_INIT: begin
        // Clearing pass over the bitmap rows after reset.
        cmd_o.init_wr = 1'b1;
        if (sts_i.init_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.range_err) begin
          st_d    = ST_RANGE;
          state_d = S_FIN;
        end else if (!sts_i.is_free) begin
          ph_d        = PH_SCAN;
          cmd_o.phase = PH_SCAN;
          cmd_o.start = 1'b1;
          state_d     = S_RD;
        end else begin
          cmd_o.sub_init = 1'b1;
          state_d        = S_SUB;
        end
      end
      S_SUB: begin
        if (sts_i.sub_more) begin
          ph_d        = PH_SUB;
          cmd_o.phase = PH_SUB;
          cmd_o.start = 1'b1;
          state_d     = S_RD;
        end else if (!sts_i.is_free) begin
          st_d    = ST_DONE;
          state_d = S_FIN;
        end else begin
          cmd_o.walk_init = 1'b1;
          state_d         = S_WALK;
        end
      end
      S_RD: begin
        state_d = S_ACT;
      end
      S_ACT: begin
        cmd_o.act = 1'b1;
        case (ph_q)
          PH_SCAN: begin
            if (sts_i.hit) begin
              state_d = S_ANC;
            end else if (sts_i.last_row) begin
              st_d    = ST_NOSPACE;
              state_d = S_FIN;
            end else begin
              cmd_o.next_row = 1'b1;
              state_d        = S_RD;
            end
          end
          PH_ANC: begin
            cmd_o.anc_step = 1'b1;
            state_d        = S_ANC;
          end
          PH_SUB: begin
            if (sts_i.last_row) begin
              cmd_o.sub_step = 1'b1;
              state_d        = S_SUB;
            end else begin
              cmd_o.next_row = 1'b1;
              state_d        = S_RD;
            end
          end
          PH_TEST: begin
            if (sts_i.hit) begin
              cmd_o.walk_step = 1'b1;
              state_d         = S_PAR;
            end else begin
              st_d    = ST_DONE;
              state_d = S_FIN;
            end
          end
          PH_CLRP: begin
            state_d = S_WALK;
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end
      S_ANC: begin
        if (sts_i.anc_zero) begin
          cmd_o.sub_init = 1'b1;
          state_d        = S_SUB;
        end else begin
          ph_d        = PH_ANC;
          cmd_o.phase = PH_ANC;
          cmd_o.start = 1'b1;
          state_d     = S_RD;
        end
      end
      S_WALK: begin
        if (sts_i.lv_zero) begin
          st_d    = ST_DONE;
          state_d = S_FIN;
        end else begin
          ph_d        = PH_TEST;
          cmd_o.phase = PH_TEST;
          cmd_o.start = 1'b1;
          state_d     = S_RD;
        end
      end
      S_PAR: begin
        ph_d        = PH_CLRP;
        cmd_o.phase = PH_CLRP;
        cmd_o.start = 1'b1;
        state_d     = S_RD;
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/bbta_datapath.sv @@
// Datapath of the buddy bitmap tree allocator: bitmap row memory, node and
// range registers, row mask, free-bit search and the result register.
// Depends on bbta_pkg.
module bbta_datapath #(
  parameter int unsigned MAX_LEVELS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bbta_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       func_i,
  input  logic [2:0]                 req_level_i,
  input  logic [7:0]                 node_index_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [7:0]                 granted_index_o,
  input  bbta_pkg::cmd_t             cmd_i,
  output bbta_pkg::sts_t             sts_o
);
  import bbta_pkg::*;

  localparam int unsigned NW   = MAX_LEVELS;              // node index width
  localparam int unsigned RB   = (MAX_LEVELS >= 5) ? 4 : MAX_LEVELS - 1;
  localparam int unsigned RW   = 1 << RB;                 // nodes per row
  localparam int unsigned RAW  = NW - RB;                 // row address width
  localparam int unsigned ROWS = 1 << RAW;
  localparam int unsigned LVW  = $clog2(MAX_LEVELS);
  localparam int unsigned NLW  = $clog2(MAX_LEVELS + 1);

  logic [RW-1:0]  mem_q [ROWS];
  logic [RW-1:0]  rdata_q;

  logic [CFG_W-1:0] cfg_q;
  logic [RAW-1:0]   row_q, row_d;
  logic             out_valid_q;
  logic [1:0]       status_q;
  logic [7:0]       granted_q;

  logic           func_q;
  logic           err_q;
  logic [LVW-1:0] level_q;
  logic [NW-1:0]  node_q;
  logic [NLW-1:0] nlev_q;
  logic [NW-1:0]  cur_q;
  logic [LVW-1:0] lv_q;
  logic [NLW-1:0] d_q;
  logic [NW-1:0]  base_q;
  logic [LVW-1:0] sz_q;
  logic [RAW-1:0] end_q;

  logic [4:0]     cfg5, nlev5;
  logic           err_in;
  logic [NW-1:0]  base_new;
  logic [LVW-1:0] sz_new;
  logic [NW-1:0]  last_node;
  logic [RW-1:0]  mask, free_bits, wdata;
  logic [RB-1:0]  fb;
  logic [NW-1:0]  found;
  logic           hit;
  logic           we;
  logic           set_bits;

  // Effective level count: the register saturated to 1 .. MAX_LEVELS.
  assign cfg5 = {1'b0, cfg_q};
  always_comb begin
    if (cfg5 == 5'd0) begin
      nlev5 = 5'd1;
    end else if (cfg5 > 5'(MAX_LEVELS)) begin
      nlev5 = 5'(MAX_LEVELS);
    end else begin
      nlev5 = cfg5;
    end
  end

  assign err_in = ({2'b00, req_level_i} >= nlev5) ||
                  (func_i && ((node_index_i >> req_level_i) != 8'd1));

  // Range of the next row pass: base node and log2 of its length.
  always_comb begin
    case (cmd_i.phase)
      PH_SCAN: begin
        base_new = NW'(1) << level_q;
        sz_new   = level_q;
      end
      PH_SUB: begin
        base_new = node_q << d_q;
        sz_new   = LVW'(d_q);
      end
      PH_TEST: begin
        base_new = cur_q ^ NW'(1);
        sz_new   = '0;
      end
      default: begin
        base_new = cur_q;
        sz_new   = '0;
      end
    endcase
  end
  assign last_node = base_new + (NW'(1) << sz_new) - NW'(1);

  // Row mask of the range and the lowest free bit within it.
  always_comb begin
    for (int j = 0; j < RW; j++) begin
      mask[j] = (sz_q >= LVW'(RB)) || (((RB'(j) ^ base_q[RB-1:0]) >> sz_q) == '0);
    end
    free_bits = ~rdata_q & mask;
    fb = '0;
    for (int j = RW - 1; j >= 0; j--) begin
      if (free_bits[j]) begin
        fb = RB'(j);
      end
    end
  end
  assign found = {row_q, fb};

  always_comb begin
    case (cmd_i.phase)
      PH_SCAN: hit = |free_bits;
      PH_TEST: hit = ~|(rdata_q & mask);
      default: hit = 1'b0;
    endcase
  end

  assign set_bits = (cmd_i.phase == PH_ANC) || ((cmd_i.phase == PH_SUB) && !func_q);
  assign we = cmd_i.init_wr ||
              (cmd_i.act && ((cmd_i.phase == PH_ANC) || (cmd_i.phase == PH_SUB) ||
                             (cmd_i.phase == PH_CLRP)));
  always_comb begin
    if (cmd_i.init_wr) begin
      wdata = '0;
    end else if (set_bits) begin
      wdata = rdata_q | mask;
    end else begin
      wdata = rdata_q & ~mask;
    end
  end

  // Bitmap rows; the read is registered and always follows row_q.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[row_q] <= wdata;
    end
    rdata_q <= mem_q[row_q];
  end

  always_comb begin
    row_d = row_q;
    if (cmd_i.start) begin
      row_d = base_new[NW-1:RB];
    end else if (cmd_i.next_row || cmd_i.init_wr) begin
      row_d = row_q + RAW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= LEVELS_RESET;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      row_q <= row_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      err_q   <= err_in;
      level_q <= LVW'(req_level_i);
      node_q  <= NW'(node_index_i);
      nlev_q  <= NLW'(nlev5);
    end
    if (cmd_i.act && (cmd_i.phase == PH_SCAN) && hit) begin
      node_q <= found;
      cur_q  <= found >> 1;
    end
    if (cmd_i.anc_step) begin
      cur_q <= cur_q >> 1;
    end
    if (cmd_i.sub_init) begin
      d_q <= '0;
    end else if (cmd_i.sub_step) begin
      d_q <= d_q + NLW'(1);
    end
    if (cmd_i.walk_init) begin
      cur_q <= node_q;
      lv_q  <= level_q;
    end else if (cmd_i.walk_step) begin
      cur_q <= cur_q >> 1;
      lv_q  <= lv_q - LVW'(1);
    end
    if (cmd_i.start) begin
      base_q <= base_new;
      sz_q   <= sz_new;
      end_q  <= last_node[NW-1:RB];
    end
    if (cmd_i.finish) begin
      status_q  <= cmd_i.fin_status;
      granted_q <= ((cmd_i.fin_status == ST_DONE) && !func_q) ? 8'(node_q) : 8'd0;
    end
  end

  assign sts_o.range_err = err_q;
  assign sts_o.is_free   = func_q;
  assign sts_o.hit       = hit;
  assign sts_o.last_row  = (row_q == end_q);
  assign sts_o.anc_zero  = (cur_q == '0);
  assign sts_o.sub_more  = ((NLW+1)'(level_q) + (NLW+1)'(d_q)) < (NLW+1)'(nlev_q);
  assign sts_o.lv_zero   = (lv_q == '0);
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;
  assign sts_o.init_last = (row_q == {RAW{1'b1}});

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign granted_index_o = granted_q;

endmodule

@@ rtl/core/buddy_bitmap_tree_allocator.sv @@
// Buddy allocator over a heap-numbered bitmap tree (root is node 1). The busy
// bits sit in a memory of rows of 16 nodes (fewer for very small trees); every
// row visited is read and then written back or tested. An allocate searches
// the rows of its level for a free node, marks each ancestor busy and then
// marks each subtree level. A free clears each subtree level, then climbs
// while the buddy is free, clearing each parent, until it reaches the root or
// a busy buddy stops it. A request out of range goes straight to its result.
// An item cannot finish while the previous result still waits to be taken.
// One item is worked at a time; its result waits in an output register while
// the next item is taken. After reset a clearing pass writes all
// 2^(MAX_LEVELS-4) bitmap rows (two for trees below five levels) before the
// first item is accepted.
module buddy_bitmap_tree_allocator #(
  parameter int unsigned MAX_LEVELS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bbta_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       func_i,
  input  logic [2:0]                 req_level_i,
  input  logic [7:0]                 node_index_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [7:0]                 granted_index_o
);
  import bbta_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bbta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bbta_datapath #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .func_i          (func_i),
    .req_level_i     (req_level_i),
    .node_index_i    (node_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .granted_index_o (granted_index_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

@@ rtl/core/bbta_checker.sv @@
// Port-level checker for the buddy bitmap tree allocator, bound to the top.
// Depends on bbta_pkg.
module bbta_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o,
  input logic [7:0] granted_index_o
);
  import bbta_pkg::*;

  // Items accepted whose result has not yet been taken.
  logic [1:0] pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_valid_i && in_ready_o) - 2'(out_valid_o && out_ready_i);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(status_o) && $stable(granted_index_o))
    else $error("result changed while stalled");

  a_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_DONE) |-> granted_index_o == 8'd0)
    else $error("granted index set on a failed request");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result shown without an outstanding item");

  a_one_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (pend_q == 2'd0) || (pend_q == 2'd1))
    else $error("item taken while two are outstanding");

endmodule

bind buddy_bitmap_tree_allocator bbta_checker u_bbta_checker (.*);

@@ test/tb.sv @@
// Self-checking testbench for buddy_bitmap_tree_allocator: directed requests, then random
// alloc/free traffic under several level settings, checked against a busy-map predictor.
// Depends on bbta_pkg and the allocator RTL only.
`timescale 1ns / 100ps

module tb;
  import bbta_pkg::*;

  localparam int unsigned TREE_LEVELS = 8;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned MAX_PRINTS = 100;
  localparam bit OP_ALLOC = 1'b0;
  localparam bit OP_FREE = 1'b1;
  localparam bit CHK = 1'b1;
  localparam bit PRED = 1'b0;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] granted;
  } grant_t;

  typedef struct {
    logic [7:0] idx;
    logic [2:0] lvl;
  } held_t;

  typedef struct {
    bit         is_cfg;
    bit         op;
    logic [2:0] lvl;
    logic [7:0] idx;
    logic [3:0] cfg;
    bit         typed;
    logic [1:0] st;
    logic [7:0] gr;
  } plan_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [3:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       func_i;
  logic [2:0] req_level_i;
  logic [7:0] node_index_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [1:0] status_o;
  logic [7:0] granted_index_o;

  // Predictor state: one busy bit per heap node and the level register.
  bit          busy_map [0:(1 << TREE_LEVELS) - 1];
  logic [3:0]  level_count;

  grant_t      grant_q [$];
  held_t       held [$];
  plan_row_t   plan [$];

  int unsigned quiet_cycles;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned n_grant, n_nospace, n_range, n_free, n_items, n_settings;
  bit          jitter_on;
  bit          hold_req;
  int unsigned hold_left;

  always #2 clk_i = ~clk_i;

  buddy_bitmap_tree_allocator #(
    .MAX_LEVELS(TREE_LEVELS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .req_level_i    (req_level_i),
    .node_index_i   (node_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .granted_index_o(granted_index_o)
  );

  function automatic int unsigned live_levels();
    if (level_count == 0) return 1;
    if (level_count > TREE_LEVELS) return TREE_LEVELS;
    return level_count;
  endfunction

  // Writes a node and all its descendants down to the last level in use.
  function automatic void paint_subtree(int unsigned node, int unsigned lvl,
                                        int unsigned nlev, bit v);
    int unsigned d, i;
    for (d = 0; lvl + d < nlev; d++) begin
      for (i = node << d; i < ((node + 1) << d); i++) busy_map[i] = v;
    end
  endfunction

  function automatic grant_t predict_grant(bit op, logic [2:0] lvl, logic [7:0] idx);
    grant_t      r;
    int unsigned nlev, lo, hi, n, cur, lv;
    nlev = live_levels();
    r.status = ST_DONE;
    r.granted = 8'd0;
    if (lvl >= nlev) begin
      r.status = ST_RANGE;
    end else if (op == OP_ALLOC) begin
      lo = 1 << lvl;
      hi = lo << 1;
      n = lo;
      while (n < hi && busy_map[n]) n++;
      if (n == hi) begin
        r.status = ST_NOSPACE;
      end else begin
        for (cur = n >> 1; cur != 0; cur >>= 1) busy_map[cur] = 1'b1;
        paint_subtree(n, lvl, nlev, 1'b1);
        r.granted = n[7:0];
      end
    end else if ((idx >> lvl) != 1) begin
      r.status = ST_RANGE;
    end else begin
      paint_subtree(idx, lvl, nlev, 1'b0);
      // Merge upward for as long as the buddy of the current node is free.
      cur = idx;
      lv = lvl;
      while (lv > 0 && !busy_map[cur ^ 1]) begin
        cur >>= 1;
        busy_map[cur] = 1'b0;
        lv--;
      end
    end
    return r;
  endfunction

  function automatic void add_req(bit op, int lvl, int idx, bit typed, int st, int gr);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.op = op;
    row.lvl = 3'(lvl);
    row.idx = 8'(idx);
    row.cfg = 4'd0;
    row.typed = typed;
    row.st = 2'(st);
    row.gr = 8'(gr);
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(int v);
    plan_row_t row;
    row = '{default: 0};
    row.is_cfg = 1'b1;
    row.cfg = 4'(v);
    plan.push_back(row);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < MAX_PRINTS)
      $display("%0t: mismatch in %s at result %0d: got %0d, expected %0d",
               $realtime, what, results_seen, got, want);
    mismatches++;
  endtask

  // Offers one item, holds it until taken, then sometimes leaves a gap.
  task automatic send_request(bit op, logic [2:0] lvl, logic [7:0] idx, bit typed,
                              grant_t typed_res);
    grant_t g;
    g = predict_grant(op, lvl, idx);
    if (typed) g = typed_res;
    case (g.status)
      ST_DONE:    if (op == OP_ALLOC) n_grant++; else n_free++;
      ST_NOSPACE: n_nospace++;
      default:    n_range++;
    endcase
    if (op == OP_ALLOC && g.status == ST_DONE) held.push_back('{g.granted, lvl});
    grant_q.push_back(g);
    n_items++;
    in_valid_i <= 1'b1;
    func_i <= op;
    req_level_i <= lvl;
    node_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    if (jitter_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // The level register only changes once every pending result is out.
  task automatic write_levels(logic [3:0] v);
    in_valid_i <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    level_count = v;
    n_settings++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : check_results
    grant_t want;
    if (rst_ni === 1'b1) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (grant_q.size() == 0) begin
          report_mismatch("unexpected result, status", status_o, 0);
        end else begin
          want = grant_q.pop_front();
          if (status_o !== want.status) report_mismatch("status", status_o, want.status);
          if (granted_index_o !== want.granted)
            report_mismatch("granted_index", granted_index_o, want.granted);
        end
      end
    end
  end

  initial begin : result_sink
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (jitter_on && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 17);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    @(posedge rst_ni);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
    $display("[buddy_bitmap_tree_allocator] ERROR");
    $finish;
  end

  initial begin : stimulus
    plan_row_t   row;
    held_t       h;
    bit          op;
    logic [2:0]  lvl;
    logic [7:0]  idx;
    logic [3:0]  lv_cfg;
    int unsigned ph, k, count, eff, top, pick;

    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= 4'd0;
    in_valid_i <= 1'b0;
    func_i <= OP_ALLOC;
    req_level_i <= 3'd0;
    node_index_i <= 8'd0;
    foreach (busy_map[i]) busy_map[i] = 1'b0;
    level_count = LEVELS_RESET;
    jitter_on = 1'b1;
    hold_req = 1'b0;
    hold_left = 0;

    // Full tree: root grab, out of space, full release, buddies and merges.
    add_req(OP_ALLOC, 0, 0,   CHK, ST_DONE,    1);
    add_req(OP_ALLOC, 7, 0,   CHK, ST_NOSPACE, 0);
    add_req(OP_ALLOC, 3, 0,   CHK, ST_NOSPACE, 0);
    add_req(OP_FREE,  0, 1,   CHK, ST_DONE,    0);
    add_req(OP_ALLOC, 7, 0,   CHK, ST_DONE,    128);
    add_req(OP_ALLOC, 7, 0,   CHK, ST_DONE,    129);
    add_req(OP_ALLOC, 1, 0,   CHK, ST_DONE,    3);
    add_req(OP_FREE,  7, 128, CHK, ST_DONE,    0);
    add_req(OP_FREE,  7, 129, PRED, 0, 0);
    add_req(OP_ALLOC, 2, 0,   PRED, 0, 0);
    add_req(OP_FREE,  3, 7,   CHK, ST_RANGE,   0);
    // Freeing a node nobody holds is still done.
    add_req(OP_FREE,  7, 255, CHK, ST_DONE,    0);
    add_req(OP_FREE,  0, 0,   CHK, ST_RANGE,   0);
    add_req(OP_FREE,  7, 0,   CHK, ST_RANGE,   0);
    add_req(OP_ALLOC, 7, 255, PRED, 0, 0);
    add_req(OP_FREE,  1, 255, CHK, ST_RANGE,   0);
    add_req(OP_FREE,  0, 1,   CHK, ST_DONE,    0);
    // A single level, set directly and through a zero register value.
    add_cfg(1);
    add_req(OP_ALLOC, 1, 0,   CHK, ST_RANGE,   0);
    add_req(OP_ALLOC, 0, 0,   CHK, ST_DONE,    1);
    add_req(OP_ALLOC, 0, 0,   CHK, ST_NOSPACE, 0);
    add_req(OP_FREE,  0, 1,   CHK, ST_DONE,    0);
    add_cfg(0);
    add_req(OP_ALLOC, 0, 0,   CHK, ST_DONE,    1);
    add_req(OP_FREE,  7, 128, CHK, ST_RANGE,   0);
    add_req(OP_FREE,  0, 1,   CHK, ST_DONE,    0);
    // Three levels bound the subtree marking.
    add_cfg(3);
    add_req(OP_ALLOC, 2, 0,   CHK, ST_DONE,    4);
    add_req(OP_ALLOC, 1, 0,   CHK, ST_DONE,    3);
    add_req(OP_FREE,  2, 4,   CHK, ST_DONE,    0);
    add_req(OP_ALLOC, 3, 0,   CHK, ST_RANGE,   0);
    add_req(OP_FREE,  1, 3,   PRED, 0, 0);
    // A register value above the maximum saturates.
    add_cfg(15);
    add_req(OP_ALLOC, 7, 0,   PRED, 0, 0);
    add_req(OP_FREE,  7, 128, PRED, 0, 0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[r]) begin
      row = plan[r];
      if (row.is_cfg) write_levels(row.cfg);
      else send_request(row.op, row.lvl, row.idx, row.typed, {row.st, row.gr});
    end

    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0:       lv_cfg = 4'd8;
        1:       lv_cfg = 4'd15;
        2:       lv_cfg = 4'd2;
        3:       lv_cfg = 4'd0;
        4:       lv_cfg = 4'd1;
        5:       lv_cfg = 4'($urandom_range(0, 15));
        default: lv_cfg = 4'd8;
      endcase
      write_levels(lv_cfg);
      if (ph == 1) hold_req = 1'b1;
      if (ph == 6) jitter_on = 1'b0;
      eff = live_levels();
      top = eff - 1;
      count = (eff <= 2) ? 80 : 210;
      for (k = 0; k < count; k++) begin
        pick = $urandom_range(0, 99);
        idx = 8'($urandom_range(0, 255));
        if (pick < 45) begin
          op = OP_ALLOC;
          // Mostly deep levels, so the tree fills gradually.
          if ($urandom_range(0, 3) != 0)
            lvl = 3'(top - $urandom_range(0, (top < 3) ? top : 3));
          else lvl = 3'($urandom_range(0, top));
        end else if (pick < 80 && held.size() != 0) begin
          op = OP_FREE;
          pick = $urandom_range(0, held.size() - 1);
          h = held[pick];
          held.delete(pick);
          lvl = h.lvl;
          idx = h.idx;
        end else if (pick < 90) begin
          op = OP_FREE;
          lvl = 3'($urandom_range(0, top));
          idx = 8'((1 << lvl) | ($urandom_range(0, 255) & ((1 << lvl) - 1)));
        end else begin
          op = 1'($urandom_range(0, 1));
          lvl = 3'($urandom_range(0, 7));
        end
        send_request(op, lvl, idx, PRED, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Ran %0d requests under %0d level settings, one long output stall included.",
             n_items, n_settings);
    $display("Expected %0d grants, %0d frees, %0d out-of-space and %0d range results.",
             n_grant, n_free, n_nospace, n_range);
    if (mismatches == 0) begin
      $display("[buddy_bitmap_tree_allocator] OK");
    end else begin
      $display("%0d mismatches in %0d results", mismatches, results_seen);
      $display("[buddy_bitmap_tree_allocator] ERROR");
    end
    $finish;
  end

endmodule
